// ===== rtl/core/srbs_pkg.sv =====
// shared types and constants for the sorted remainder body store
package srbs_pkg;

	localparam int unsigned OP_W    = 2;
	localparam int unsigned SLICE_W = 6;
	localparam int unsigned REM_W   = 8;
	// index compares run at this width, enough for up to 511 slots
	localparam int unsigned IDX_W   = 9;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// operation codes as they arrive on the input channel
	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2
	} op_kind_t;

	// classified command handed from the front to the back
	typedef struct packed {
		op_kind_t           kind;
		logic [SLICE_W-1:0] start;
		logic [SLICE_W-1:0] lim;
		logic [REM_W-1:0]   rem;
	} cmd_t;

endpackage

// ===== rtl/core/sorted_remainder_body_store.sv =====
// Sorted remainder body store: BODY_SLOTS 8-bit remainders kept sorted within slices that
// each transaction names. Lookup, insert and remove each take one transaction and return
// one found flag. A transaction is accepted into a two-entry command queue; it is popped
// from the queue head once the output register is empty or being taken, and its result is
// loaded into the output register as it is popped. One transaction completes per cycle
// when neither side stalls: every slot has its own compare and shift cell, so the search
// and the array update are done together, combinationally, for the popped command.
// Reset clears all slots to zero at once.
module sorted_remainder_body_store import srbs_pkg::*; #(
	parameter int unsigned BODY_SLOTS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [OP_W-1:0]    operation,
	input  logic [SLICE_W-1:0] slice_start,
	input  logic [SLICE_W-1:0] slice_end,
	input  logic [REM_W-1:0]   remainder,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found
);

	cmd_t front_cmd;
	cmd_t back_cmd;
	logic back_valid;
	logic back_pop;

	// classify the incoming transaction
	srbs_front #(
		.BODY_SLOTS(BODY_SLOTS)
	) u_front (
		.operation  (operation),
		.slice_start(slice_start),
		.slice_end  (slice_end),
		.remainder  (remainder),
		.cmd        (front_cmd)
	);

	// decouple front from back
	srbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(in_valid),
		.push_stall(in_stall),
		.push_cmd  (front_cmd),
		.pop_valid (back_valid),
		.pop_cmd   (back_cmd),
		.pop       (back_pop)
	);

	// search, update and report
	srbs_back #(
		.BODY_SLOTS(BODY_SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(back_valid),
		.cmd      (back_cmd),
		.cmd_pop  (back_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found    (found)
	);

endmodule

// ===== rtl/core/srbs_front.sv =====
// front end: classifies an incoming transaction and clamps its slice end
module srbs_front import srbs_pkg::*; #(
	parameter int unsigned BODY_SLOTS = 32
) (
	input  logic [OP_W-1:0]    operation,
	input  logic [SLICE_W-1:0] slice_start,
	input  logic [SLICE_W-1:0] slice_end,
	input  logic [REM_W-1:0]   remainder,
	output cmd_t               cmd
);

	localparam logic [IDX_W-1:0] SLOTS_W = IDX_W'(BODY_SLOTS);

	logic [IDX_W-1:0] end_wide;

	assign end_wide = {{(IDX_W-SLICE_W){1'b0}}, slice_end};

	// unused operation code falls back to lookup; clamp end to the array size,
	// the clamped value never exceeds slice_end
	always_comb begin
		unique case (operation)
			OP_INSERT: cmd.kind = OP_INSERT;
			OP_REMOVE: cmd.kind = OP_REMOVE;
			default:   cmd.kind = OP_LOOKUP;
		endcase
		if (end_wide > SLOTS_W) begin
			cmd.lim = SLOTS_W[SLICE_W-1:0];
		end else begin
			cmd.lim = slice_end;
		end
		cmd.start = slice_start;
		cmd.rem   = remainder;
	end

endmodule

// ===== rtl/core/srbs_queue.sv =====
// short command queue between front and back
module srbs_queue import srbs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_stall,
	input  cmd_t push_cmd,
	output logic pop_valid,
	output cmd_t pop_cmd,
	input  logic pop
);

	localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
	localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;

	assign push_stall = (cnt_q == FULL_CNT);
	assign push       = push_valid && !push_stall;
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== rtl/core/srbs_back.sv =====
// back end: slot array with per-slot compare and shift, plus the result register
module srbs_back import srbs_pkg::*; #(
	parameter int unsigned BODY_SLOTS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic out_valid,
	input  logic out_stall,
	output logic found
);

	logic [REM_W-1:0]      body_q [BODY_SLOTS];
	logic [REM_W-1:0]      nxt    [BODY_SLOTS];
	logic [BODY_SLOTS-1:0] m;       // in slice and not below the remainder
	logic [BODY_SLOTS-1:0] p;       // slot index at or beyond the search position
	logic [BODY_SLOTS-1:0] hit_at;
	logic                  hit;
	logic                  is_ins;
	logic                  is_rem;
	logic                  out_valid_q;
	logic                  found_q;

	assign is_ins = (cmd.kind == OP_INSERT);
	assign is_rem = (cmd.kind == OP_REMOVE);

	// one compare cell per slot
	for (genvar i = 0; i < BODY_SLOTS; i++) begin : g_slot
		localparam logic [IDX_W-1:0] IDX = IDX_W'(i);

		logic             in_slice;
		logic             past_lim;
		logic             prev_p;
		logic             prev_m;
		logic [REM_W-1:0] prev_val;
		logic [REM_W-1:0] next_val;

		assign in_slice = (IDX >= {{(IDX_W-SLICE_W){1'b0}}, cmd.start}) &&
		                  (IDX <  {{(IDX_W-SLICE_W){1'b0}}, cmd.lim});
		assign past_lim = (IDX >= {{(IDX_W-SLICE_W){1'b0}}, cmd.lim});
		assign m[i]     = in_slice && (body_q[i] >= cmd.rem);
		assign p[i]     = (|m[i:0]) || past_lim;

		// neighbours; the ends of the array see nothing
		if (i == 0) begin : g_first
			assign prev_p   = 1'b0;
			assign prev_m   = 1'b0;
			assign prev_val = '0;
		end else begin : g_mid
			assign prev_p   = p[i-1];
			assign prev_m   = |m[i-1:0];
			assign prev_val = body_q[i-1];
		end
		if (i == BODY_SLOTS - 1) begin : g_last
			assign next_val = '0;
		end else begin : g_inner
			assign next_val = body_q[i+1];
		end

		// exact match at the first qualifying slot
		assign hit_at[i] = m[i] && !prev_m && (body_q[i] == cmd.rem);

		// insert writes at the position and shifts right; remove shifts left
		assign nxt[i] = (is_ins && p[i] && !prev_p) ? cmd.rem :
		                (is_ins && prev_p)          ? prev_val :
		                (is_rem && hit && p[i])     ? next_val :
		                                              body_q[i];
	end

	assign hit = |hit_at;

	// result register parts the back end from the output channel
	assign cmd_pop = cmd_valid && (!out_valid_q || !out_stall);

	// slot array
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < BODY_SLOTS; k++) begin
				body_q[k] <= '0;
			end
		end else if (cmd_pop) begin
			for (int k = 0; k < BODY_SLOTS; k++) begin
				body_q[k] <= nxt[k];
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			found_q <= hit;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;

endmodule

// ===== rtl/core/srbs_checker.sv =====
// port-level checker for the sorted remainder body store, bound to the top level
module srbs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic found
);

	logic [2:0] outstanding_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (in_acc && !out_acc) begin
			outstanding_q <= outstanding_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			outstanding_q <= outstanding_q - 1'b1;
		end
	end

	// a held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found))
		else $error("result changed while stalled");

	// no result without an accepted transaction behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> outstanding_q != 3'd0)
		else $error("result with nothing outstanding");

	// queue plus result register bound the work in flight
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= 3'd3)
		else $error("too many transactions in flight");

	// an empty block never stalls its input
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q == 3'd0 |-> !in_stall)
		else $error("input stalled while empty");

endmodule

bind sorted_remainder_body_store srbs_checker u_srbs_checker (.*);
